FILE: sv/i2cms_pkg.sv
// Shared types, codes and reset constants of the I2C master bit sequencer.
package i2cms_pkg;

   localparam int CNT_WIDTH_DEFAULT = 8;
   localparam int PHASE_W = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [7:0] SHORT_DELAY_RESET = 8'd2;
   localparam logic [7:0] MID_DELAY_RESET = 8'd5;
   localparam logic [7:0] LONG_DELAY_RESET = 8'd8;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
   localparam logic [7:0] POLL_COUNT_MAX = 8'hFF;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_DELAY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MID_DELAY = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_DELAY = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT = 2'd3;

   typedef enum logic [2:0] {
      MODE_START = 3'd0,
      MODE_STOP = 3'd1,
      MODE_WRITE = 3'd2,
      MODE_READ = 3'd3,
      MODE_ACK = 3'd4,
      MODE_NAK = 3'd5,
      MODE_WAIT_ACK = 3'd6
   } mode_type;

   // Step of the running command; the meaning of each step depends on the mode.
   typedef enum logic [PHASE_W-1:0] {
      STEP_0 = 5'd0,
      STEP_1 = 5'd1,
      STEP_2 = 5'd2,
      STEP_3 = 5'd3,
      STEP_4 = 5'd4,
      STEP_IDLE = 5'd31
   } phase_type;

   typedef struct packed {
      logic [7:0] short_delay;
      logic [7:0] mid_delay;
      logic [7:0] long_delay;
      logic [7:0] ack_timeout;
   } cfg_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] mode;
      logic [7:0] write_data;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      phase_type  phase;
      mode_type   mode;
      logic [3:0] bit_index;
      logic [7:0] shift;
      logic [7:0] poll_count;
      logic       scl;
      logic       sda;
      logic [7:0] read_hold;
      logic       missing_hold;
   } seq_state_type;

   // Result word, last field in the lowest bits.
   typedef struct packed {
      logic [7:0] ack_poll_count;
      logic       ack_missing;
      logic [7:0] read_data;
      logic       done_res;
      logic       busy_res;
      logic       sda_out;
      logic       scl_out;
   } rsp_type;

endpackage

FILE: sv/i2cms_csr.sv
// Configuration registers of the I2C master bit sequencer.
module i2cms_csr
   import i2cms_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SHORT_DELAY: cfg_in.short_delay = csr_wdata;
            CSR_MID_DELAY: cfg_in.mid_delay = csr_wdata;
            CSR_LONG_DELAY: cfg_in.long_delay = csr_wdata;
            CSR_ACK_TIMEOUT: cfg_in.ack_timeout = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_delay <= SHORT_DELAY_RESET;
         cfg_ff.mid_delay <= MID_DELAY_RESET;
         cfg_ff.long_delay <= LONG_DELAY_RESET;
         cfg_ff.ack_timeout <= ACK_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/i2cms_step.sv
// One tick of the sequencer: next pin levels, counters and result word.
module i2cms_step
   import i2cms_pkg::*;
#(
   parameter int COUNTER_WIDTH = CNT_WIDTH_DEFAULT
) (
   input  seq_state_type            state_cur,
   input  logic [COUNTER_WIDTH-1:0] delay_cur,
   input  item_type                 item,
   input  cfg_type                  cfg,
   output seq_state_type            state_nxt,
   output logic [COUNTER_WIDTH-1:0] delay_nxt,
   output rsp_type                  rsp
);

   localparam int CMP_W = COUNTER_WIDTH + 8;

   // Hold of d ticks: counter gets d-1, a zero register counts as one tick,
   // and a hold too long for the counter is cut to its maximum.
   function automatic logic [COUNTER_WIDTH-1:0] hold_load(input logic [7:0] d);
      logic [7:0]       v;
      logic [CMP_W-1:0] v_ext;
      logic [CMP_W-1:0] max_ext;
      v = (d == 8'd0) ? 8'd0 : d - 8'd1;
      v_ext = CMP_W'(v);
      max_ext = CMP_W'({COUNTER_WIDTH{1'b1}});
      return (v_ext > max_ext) ? COUNTER_WIDTH'(max_ext) : COUNTER_WIDTH'(v_ext);
   endfunction

   logic       start_cmd;
   logic       run_adv;
   mode_type   cur_mode;
   phase_type  cur_phase;
   logic [7:0] cur_shift;
   logic [3:0] bit_inc;
   phase_type  eff_phase;
   logic [3:0] pre_bit;
   logic [7:0] pre_shift;
   logic       pre_scl;
   logic       pre_sda;
   logic       poll_out;
   logic [7:0] poll_sat;
   logic       wait_retry;
   phase_type  next_phase;
   logic       done;

   assign start_cmd = (state_cur.phase == STEP_IDLE) && item.cmd_valid
                      && (item.mode <= MODE_WAIT_ACK);
   assign run_adv = start_cmd
                    || ((state_cur.phase != STEP_IDLE) && (delay_cur == '0));
   assign cur_mode = start_cmd ? mode_type'(item.mode) : state_cur.mode;
   assign cur_phase = start_cmd ? STEP_0 : state_cur.phase;
   assign cur_shift = start_cmd ? item.write_data : state_cur.shift;
   assign bit_inc = state_cur.bit_index + 4'd1;
   assign poll_out = state_cur.poll_count >= cfg.ack_timeout;
   assign poll_sat = (state_cur.poll_count == POLL_COUNT_MAX) ? state_cur.poll_count
                                                               : state_cur.poll_count + 8'd1;
   assign wait_retry = item.sda_in && !poll_out;

   // Steps that take no time fold into the step that follows them; a step
   // of STEP_IDLE here means the command ends on this tick.
   always_comb begin
      eff_phase = cur_phase;
      pre_bit = state_cur.bit_index;
      pre_shift = cur_shift;
      pre_scl = state_cur.scl;
      pre_sda = state_cur.sda;
      case (cur_mode)
         MODE_START: begin
            case (cur_phase)
               STEP_0, STEP_1, STEP_2: eff_phase = cur_phase;
               default: eff_phase = STEP_IDLE;
            endcase
         end
         MODE_STOP: begin
            case (cur_phase)
               STEP_0, STEP_1, STEP_2, STEP_3: eff_phase = cur_phase;
               default: eff_phase = STEP_IDLE;
            endcase
         end
         MODE_WRITE: begin
            case (cur_phase)
               STEP_0: begin
                  eff_phase = STEP_1;
                  pre_scl = 1'b0;
                  pre_bit = 4'd0;
               end
               STEP_1, STEP_2, STEP_3: eff_phase = cur_phase;
               default: begin
                  pre_bit = bit_inc;
                  eff_phase = (bit_inc < BITS_PER_BYTE) ? STEP_1 : STEP_IDLE;
               end
            endcase
         end
         MODE_READ: begin
            case (cur_phase)
               STEP_0: begin
                  eff_phase = STEP_1;
                  pre_sda = 1'b1;
                  pre_bit = 4'd0;
                  pre_shift = 8'd0;
               end
               STEP_1, STEP_2: eff_phase = cur_phase;
               default: begin
                  pre_shift = {cur_shift[6:0], item.sda_in};
                  pre_bit = bit_inc;
                  eff_phase = (bit_inc < BITS_PER_BYTE) ? STEP_1 : STEP_IDLE;
               end
            endcase
         end
         MODE_ACK, MODE_NAK: begin
            case (cur_phase)
               STEP_0, STEP_1: eff_phase = cur_phase;
               default: eff_phase = STEP_IDLE;
            endcase
         end
         MODE_WAIT_ACK: begin
            case (cur_phase)
               STEP_0, STEP_1, STEP_2: eff_phase = cur_phase;
               default: eff_phase = STEP_IDLE;
            endcase
         end
         default: eff_phase = STEP_IDLE;
      endcase
   end

   // Next step.
   always_comb begin
      next_phase = state_cur.phase;
      if (run_adv) begin
         if (eff_phase == STEP_IDLE) begin
            next_phase = STEP_IDLE;
         end else if ((cur_mode == MODE_WAIT_ACK) && (eff_phase == STEP_2) && wait_retry) begin
            next_phase = STEP_2;
         end else begin
            next_phase = phase_type'(PHASE_W'(eff_phase) + 5'd1);
         end
      end
   end

   // Pins, counters and held results.
   always_comb begin
      state_nxt = state_cur;
      delay_nxt = delay_cur;
      done = 1'b0;
      if (run_adv) begin
         state_nxt.mode = cur_mode;
         state_nxt.bit_index = pre_bit;
         state_nxt.shift = pre_shift;
         state_nxt.scl = pre_scl;
         state_nxt.sda = pre_sda;
         done = (eff_phase == STEP_IDLE);
         case (cur_mode)
            MODE_START: begin
               case (eff_phase)
                  STEP_0: begin
                     state_nxt.sda = 1'b1;
                     delay_nxt = hold_load(cfg.mid_delay);
                  end
                  STEP_1: begin
                     state_nxt.scl = 1'b1;
                     delay_nxt = hold_load(cfg.long_delay);
                  end
                  STEP_2: begin
                     state_nxt.sda = 1'b0;
                     delay_nxt = hold_load(cfg.long_delay);
                  end
                  default: state_nxt.scl = 1'b0;
               endcase
            end
            MODE_STOP: begin
               case (eff_phase)
                  STEP_0: begin
                     state_nxt.scl = 1'b0;
                     delay_nxt = hold_load(cfg.mid_delay);
                  end
                  STEP_1: begin
                     state_nxt.sda = 1'b0;
                     delay_nxt = hold_load(cfg.long_delay);
                  end
                  STEP_2: begin
                     state_nxt.scl = 1'b1;
                     delay_nxt = hold_load(cfg.long_delay);
                  end
                  STEP_3: begin
                     state_nxt.sda = 1'b1;
                     delay_nxt = hold_load(cfg.long_delay);
                  end
                  default: state_nxt.scl = pre_scl;
               endcase
            end
            MODE_WRITE: begin
               case (eff_phase)
                  STEP_1: begin
                     state_nxt.sda = pre_shift[7];
                     state_nxt.shift = {pre_shift[6:0], 1'b0};
                     delay_nxt = hold_load(cfg.short_delay);
                  end
                  STEP_2: begin
                     state_nxt.scl = 1'b1;
                     delay_nxt = hold_load(cfg.long_delay);
                  end
                  STEP_3: begin
                     state_nxt.scl = 1'b0;
                     delay_nxt = hold_load(cfg.short_delay);
                  end
                  default: state_nxt.scl = pre_scl;
               endcase
            end
            MODE_READ: begin
               case (eff_phase)
                  STEP_1: begin
                     state_nxt.scl = 1'b0;
                     delay_nxt = hold_load(cfg.long_delay);
                  end
                  STEP_2: begin
                     state_nxt.scl = 1'b1;
                     delay_nxt = hold_load(cfg.long_delay);
                  end
                  default: state_nxt.read_hold = pre_shift;
               endcase
            end
            MODE_ACK, MODE_NAK: begin
               case (eff_phase)
                  STEP_0: begin
                     state_nxt.scl = 1'b0;
                     state_nxt.sda = (cur_mode == MODE_NAK);
                     delay_nxt = hold_load(cfg.long_delay);
                  end
                  STEP_1: begin
                     state_nxt.scl = 1'b1;
                     delay_nxt = hold_load(cfg.long_delay);
                  end
                  default: state_nxt.scl = 1'b0;
               endcase
            end
            MODE_WAIT_ACK: begin
               case (eff_phase)
                  STEP_0: begin
                     state_nxt.sda = 1'b1;
                     state_nxt.poll_count = 8'd0;
                     delay_nxt = hold_load(cfg.mid_delay);
                  end
                  STEP_1: begin
                     state_nxt.scl = 1'b1;
                     delay_nxt = hold_load(cfg.mid_delay);
                  end
                  STEP_2: begin
                     if (!item.sda_in) begin
                        state_nxt.missing_hold = 1'b0;
                        state_nxt.scl = 1'b0;
                        delay_nxt = hold_load(cfg.long_delay);
                     end else begin
                        state_nxt.poll_count = poll_sat;
                        if (poll_out) begin
                           state_nxt.missing_hold = 1'b1;
                           state_nxt.scl = 1'b0;
                           delay_nxt = hold_load(cfg.long_delay);
                        end
                     end
                  end
                  default: state_nxt.scl = pre_scl;
               endcase
            end
            default: state_nxt.scl = pre_scl;
         endcase
      end else if (state_cur.phase != STEP_IDLE) begin
         delay_nxt = delay_cur - COUNTER_WIDTH'(1);
      end
      state_nxt.phase = next_phase;
   end

   assign rsp.scl_out = state_nxt.scl;
   assign rsp.sda_out = state_nxt.sda;
   assign rsp.busy_res = (state_nxt.phase != STEP_IDLE);
   assign rsp.done_res = done;
   assign rsp.read_data = state_nxt.read_hold;
   assign rsp.ack_missing = state_nxt.missing_hold;
   assign rsp.ack_poll_count = state_nxt.poll_count;

endmodule

FILE: sv/i2c_master_bit_sequencer_core.sv
// Top level of the I2C master bit sequencer: input register, tick logic, result register.
// Throughput: one word per clock cycle while the result channel is not stalled; each word
// is one tick of the bus timing base, and the sequencer state advances through the
// single-pass tick logic between registers.
// Reset (synchronous, active high) empties both registers, releases SCL and SDA high,
// leaves the sequencer idle and loads the delay registers with 2, 5 and 8 ticks
// and the acknowledge timeout with 250 polls.
module i2c_master_bit_sequencer_core
   import i2cms_pkg::*;
#(
   parameter int COUNTER_WIDTH = CNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Command tick channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,  // write_data[7:0], sda_in[8], zeros above
   input  logic [3:0]             req_tuser,  // cmd_valid[0], mode[3:1]
   // Pin and status channel, one word per tick.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,  // scl_out[0], sda_out[1], busy_res[2],
                                              // done_res[3], read_data[11:4],
                                              // ack_missing[12], ack_poll_count[20:13]
   // Configuration write port.
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type                  cfg;
   logic                     in_valid_ff;
   logic                     in_valid_in;
   item_type                 item_ff;
   item_type                 item_in;
   seq_state_type            state_ff;
   seq_state_type            state_in;
   logic [COUNTER_WIDTH-1:0] delay_ff;
   logic [COUNTER_WIDTH-1:0] delay_in;
   rsp_type                  rsp_step;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   rsp_type                  rsp_data_ff;
   rsp_type                  rsp_data_in;
   logic                     step_go;

   i2cms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The held word is worked on whenever the result register is free or
   // is emptied at this same edge, so a word moves every cycle while that holds.
   assign step_go = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_go;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in = item_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         item_in.cmd_valid = req_tuser[0];
         item_in.mode = req_tuser[3:1];
         item_in.write_data = req_tdata[7:0];
         item_in.sda_in = req_tdata[8];
      end else if (step_go) begin
         in_valid_in = 1'b0;
      end
   end

   i2cms_step #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_step (
      .state_cur (state_ff),
      .delay_cur (delay_ff),
      .item      (item_ff),
      .cfg       (cfg),
      .state_nxt (state_in),
      .delay_nxt (delay_in),
      .rsp       (rsp_step)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (step_go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = rsp_step;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff.phase <= STEP_IDLE;
         state_ff.mode <= MODE_START;
         state_ff.bit_index <= 4'd0;
         state_ff.shift <= 8'd0;
         state_ff.poll_count <= 8'd0;
         state_ff.scl <= 1'b1;
         state_ff.sda <= 1'b1;
         state_ff.read_hold <= 8'd0;
         state_ff.missing_hold <= 1'b0;
         delay_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_go) begin
            state_ff <= state_in;
            delay_ff <= delay_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b000, rsp_data_ff};

   // The hold counter is always clear while no command runs.
   a_idle_delay_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == STEP_IDLE) |-> (delay_ff == '0))
      else $error("hold counter not clear while idle");

   // A running hold counts down by exactly one per processed tick.
   a_delay_countdown: assert property (@(posedge clock) disable iff (reset)
      (step_go && (state_ff.phase != STEP_IDLE) && (delay_ff != '0))
      |=> (delay_ff == $past(delay_ff) - COUNTER_WIDTH'(1)))
      else $error("hold counter skipped a tick");

   // A held input word waits unchanged until it is processed.
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step_go) |=> (in_valid_ff && $stable(item_ff)))
      else $error("input word lost while stalled");

   // Every processed tick lands in the result register.
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step_go |=> rsp_valid_ff)
      else $error("processed tick gave no result word");

endmodule
